// ===== hdl/kprs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprs_pkg
// Shared types, codes and helpers for the keypad press/repeat scanner.
// ----------------------------------------------------------------------------
package kprs_pkg;

    // port bit positions, keys are active low
    localparam int DOWN_BIT  = 3;
    localparam int BACK_BIT  = 2;
    localparam int ENTER_BIT = 5;

    // event key codes
    localparam logic [1:0] KEY_DOWN  = 2'd0;
    localparam logic [1:0] KEY_BACK  = 2'd1;
    localparam logic [1:0] KEY_ENTER = 2'd2;
    localparam logic [1:0] KEY_COMBO = 2'd3;

    // event kind codes
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_FIRST_DELAY     = 3'd0;
    localparam logic [2:0] REG_REPEAT_START    = 3'd1;
    localparam logic [2:0] REG_REPEAT_PERIOD   = 3'd2;
    localparam logic [2:0] REG_COMBO_DELAY     = 3'd3;
    localparam logic [2:0] REG_POWER_DOWN_TIME = 3'd4;
    localparam logic [2:0] REG_BEEP_ENABLE     = 3'd5;

    // register reset values
    localparam logic [15:0] FIRST_DELAY_RST     = 16'd2;
    localparam logic [15:0] REPEAT_START_RST    = 16'd50;
    localparam logic [15:0] REPEAT_PERIOD_RST   = 16'd10;
    localparam logic [15:0] COMBO_DELAY_RST     = 16'd100;
    localparam logic [15:0] POWER_DOWN_TIME_RST = 16'd200;
    localparam logic        BEEP_ENABLE_RST     = 1'b1;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [15:0] first_delay;
        logic [15:0] repeat_start;
        logic [15:0] repeat_period;
    } t_key_cfg;

    typedef struct packed {
        logic rel;
        logic press;
        logic repeat_ev;
    } t_key_evt;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? SAT16 : s[15:0];
    endfunction

endpackage

// ===== hdl/kprs_key_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprs_key_track
// Hold counter and next-threshold for one key, with press, auto-repeat and
// short-press release detection.
// ----------------------------------------------------------------------------
module kprs_key_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_held,
    input  kprs_pkg::t_key_cfg   i_cfg,
    output kprs_pkg::t_key_evt   o_evt,
    output logic [15:0]          o_hold_next
);
    import kprs_pkg::*;

    logic [15:0] r_hold, n_hold;
    logic [15:0] r_thr, n_thr;
    logic [16:0] repeat_lim;
    t_key_evt    evt;

    // end of the short-press window, formed without wrap
    assign repeat_lim = {1'b0, i_cfg.first_delay} + {1'b0, i_cfg.repeat_start};

    always_comb begin
        n_hold = r_hold;
        n_thr  = r_thr;
        evt    = '0;
        if (!i_held) begin
            n_hold  = '0;
            n_thr   = i_cfg.first_delay;
            evt.rel = (r_thr > i_cfg.first_delay) && ({1'b0, r_thr} <= repeat_lim);
        end else begin
            n_hold = sat_add16(r_hold, 16'd1);
            if (n_hold > r_thr) begin
                if (r_thr == i_cfg.first_delay) begin
                    n_thr     = sat_add16(r_thr, i_cfg.repeat_start);
                    evt.press = 1'b1;
                end else if ({1'b0, r_thr} >= repeat_lim) begin
                    n_thr         = sat_add16(r_thr, i_cfg.repeat_period);
                    evt.repeat_ev = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_thr  <= FIRST_DELAY_RST;
        end else if (i_en) begin
            r_hold <= n_hold;
            r_thr  <= n_thr;
        end
    end

    assign o_evt       = evt;
    assign o_hold_next = n_hold;

endmodule

// ===== hdl/keypad_press_repeat_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_press_repeat_scanner
// Key scanner with hold debounce, auto-repeat, short-press release and a
// down+back combination, one result per scan tick.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   scan in  | i_valid / o_stall  | i_key_port
//   event out| o_valid / i_stall  | o_event_valid, o_event_key, o_event_kind,
//            |                    | o_beep_start, o_power_down
//   config   | apb (psel..pready) | six registers at byte address 4*index
//
// one tick per cycle: the key counters update in the cycle the tick is
// taken and the result is in the output register on the next cycle.
// the single output register sets the rate; a tick is taken while the
// result is being read out, so only a stalled full register holds input.
// reset is synchronous and active low; config registers and key counters return to defaults.
// ----------------------------------------------------------------------------
module keypad_press_repeat_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // scan ticks
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_key_port,
    // events
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_event_valid,
    output logic [1:0]  o_event_key,
    output logic [1:0]  o_event_kind,
    output logic        o_beep_start,
    output logic        o_power_down,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kprs_pkg::*;

    // configuration registers
    logic [15:0] r_first_delay;
    logic [15:0] r_repeat_start;
    logic [15:0] r_repeat_period;
    logic [15:0] r_combo_delay;
    logic [15:0] r_power_down_time;
    logic        r_beep_enable;

    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay     <= FIRST_DELAY_RST;
            r_repeat_start    <= REPEAT_START_RST;
            r_repeat_period   <= REPEAT_PERIOD_RST;
            r_combo_delay     <= COMBO_DELAY_RST;
            r_power_down_time <= POWER_DOWN_TIME_RST;
            r_beep_enable     <= BEEP_ENABLE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FIRST_DELAY:     r_first_delay     <= pwdata[15:0];
                REG_REPEAT_START:    r_repeat_start    <= pwdata[15:0];
                REG_REPEAT_PERIOD:   r_repeat_period   <= pwdata[15:0];
                REG_COMBO_DELAY:     r_combo_delay     <= pwdata[15:0];
                REG_POWER_DOWN_TIME: r_power_down_time <= pwdata[15:0];
                REG_BEEP_ENABLE:     r_beep_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FIRST_DELAY:     prdata = {16'd0, r_first_delay};
            REG_REPEAT_START:    prdata = {16'd0, r_repeat_start};
            REG_REPEAT_PERIOD:   prdata = {16'd0, r_repeat_period};
            REG_COMBO_DELAY:     prdata = {16'd0, r_combo_delay};
            REG_POWER_DOWN_TIME: prdata = {16'd0, r_power_down_time};
            REG_BEEP_ENABLE:     prdata = {31'd0, r_beep_enable};
            default:             prdata = '0;
        endcase
    end

    // handshake
    logic r_out_valid;
    logic in_take;

    assign o_stall = r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    // key trackers
    t_key_cfg    key_cfg;
    t_key_evt    down_evt, back_evt, enter_evt;
    logic [15:0] down_hold_next, back_hold_next, enter_hold_next;
    logic        down_held, back_held, enter_held;

    assign key_cfg.first_delay   = r_first_delay;
    assign key_cfg.repeat_start  = r_repeat_start;
    assign key_cfg.repeat_period = r_repeat_period;

    assign down_held  = !i_key_port[DOWN_BIT];
    assign back_held  = !i_key_port[BACK_BIT];
    assign enter_held = !i_key_port[ENTER_BIT];

    kprs_key_track u_down (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_take),
        .i_held      (down_held),
        .i_cfg       (key_cfg),
        .o_evt       (down_evt),
        .o_hold_next (down_hold_next)
    );

    kprs_key_track u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_take),
        .i_held      (back_held),
        .i_cfg       (key_cfg),
        .o_evt       (back_evt),
        .o_hold_next (back_hold_next)
    );

    kprs_key_track u_enter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_take),
        .i_held      (enter_held),
        .i_cfg       (key_cfg),
        .o_evt       (enter_evt),
        .o_hold_next (enter_hold_next)
    );

    // combination counter
    logic [15:0] r_combo_hold, n_combo_hold;

    assign n_combo_hold = (down_held && back_held) ? sat_add16(r_combo_hold, 16'd1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo_hold <= '0;
        end else if (in_take) begin
            r_combo_hold <= n_combo_hold;
        end
    end

    // event selection, earlier branches win: combination, then back, enter, down press or repeat, then releases
    logic       n_event_valid;
    logic [1:0] n_event_key;
    logic [1:0] n_event_kind;
    logic       n_beep_start;
    logic       n_power_down;

    always_comb begin
        n_event_valid = 1'b0;
        n_event_key   = KEY_DOWN;
        n_event_kind  = KIND_PRESS;
        if (n_combo_hold > r_combo_delay) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_COMBO;
            n_event_kind  = KIND_PRESS;
        end else if (back_evt.press || back_evt.repeat_ev) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_BACK;
            n_event_kind  = back_evt.press ? KIND_PRESS : KIND_REPEAT;
        end else if (enter_evt.press || enter_evt.repeat_ev) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_ENTER;
            n_event_kind  = enter_evt.press ? KIND_PRESS : KIND_REPEAT;
        end else if (down_evt.press || down_evt.repeat_ev) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_DOWN;
            n_event_kind  = down_evt.press ? KIND_PRESS : KIND_REPEAT;
        end else if (enter_evt.rel) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_ENTER;
            n_event_kind  = KIND_RELEASE;
        end else if (back_evt.rel) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_BACK;
            n_event_kind  = KIND_RELEASE;
        end else if (down_evt.rel) begin
            n_event_valid = 1'b1;
            n_event_key   = KEY_DOWN;
            n_event_kind  = KIND_RELEASE;
        end
    end

    assign n_beep_start = r_beep_enable &&
        (down_evt.press || down_evt.repeat_ev || back_evt.press ||
         back_evt.repeat_ev || enter_evt.press || enter_evt.repeat_ev);
    assign n_power_down = enter_hold_next > r_power_down_time;

    // result register
    logic       r_event_valid;
    logic [1:0] r_event_key;
    logic [1:0] r_event_kind;
    logic       r_beep_start;
    logic       r_power_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_event_valid <= n_event_valid;
            r_event_key   <= n_event_key;
            r_event_kind  <= n_event_kind;
            r_beep_start  <= n_beep_start;
            r_power_down  <= n_power_down;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_valid = r_event_valid;
    assign o_event_key   = r_event_key;
    assign o_event_kind  = r_event_kind;
    assign o_beep_start  = r_beep_start;
    assign o_power_down  = r_power_down;

    // back-pressure only comes from a full output register
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output register");

    // a beep only accompanies a press or repeat event
    a_beep_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beep_start) |-> (o_event_valid &&
            (o_event_kind == KIND_PRESS || o_event_kind == KIND_REPEAT)))
        else $error("beep without press or repeat");

    // an empty tick reports zero key and kind
    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_event_valid) |->
            (o_event_key == KEY_DOWN && o_event_kind == KIND_PRESS && !o_beep_start))
        else $error("no event but fields not cleared");

    // the combination is only reported as a press
    a_combo_is_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_valid && o_event_key == KEY_COMBO) |->
            (o_event_kind == KIND_PRESS))
        else $error("combination with kind other than press");

endmodule
